FILE: design/stereo_linear_resampler_assert.svh
// ----------------------------------------------------------------------------
// stereo linear resampler assertion macros
// shared concurrent checks, clocked on the rising edge, disabled in reset
// ----------------------------------------------------------------------------
`ifndef STEREO_LINEAR_RESAMPLER_ASSERT_SVH
`define STEREO_LINEAR_RESAMPLER_ASSERT_SVH

// same-cycle implication
`define SLR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("stereo_linear_resampler: same-cycle check failed");

// next-cycle implication
`define SLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("stereo_linear_resampler: next-cycle check failed");

`endif

FILE: design/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg
// shared types and constants of the stereo linear resampler
// ----------------------------------------------------------------------------
`default_nettype none

package slr_pkg;

	// most results one input frame can produce
	localparam int MAX_RESULTS = 8;
	localparam int CNT_W       = $clog2(MAX_RESULTS);

	// output format
	localparam int OUT_BITS = 16;
	localparam logic signed [OUT_BITS-1:0] OUT_MAX = 16'sh7FFF;
	localparam logic signed [OUT_BITS-1:0] OUT_MIN = 16'sh8000;
	localparam logic [OUT_BITS:0] MAG_LIMIT_POS = 17'd32767;
	localparam logic [OUT_BITS:0] MAG_LIMIT_NEG = 17'd32768;

	// scale factor 32767 = 2^15 - 1
	localparam int SCALE_LOG2 = 15;

	// register file
	localparam int APB_ADDR_W = 3;
	localparam logic REG_PHASE_STEP = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} slr_state_t;

	typedef struct packed {
		logic load_first;
		logic load_next;
		logic skip;
		logic issue;
		logic issue_last;
	} slr_cmd_t;

	typedef struct packed {
		logic have_prev;
		logic phase_lt_one;
		logic sum_lt_one;
		logic adv;
	} slr_status_t;

endpackage

`default_nettype wire

FILE: design/stereo_linear_resampler.sv
// ----------------------------------------------------------------------------
// stereo_linear_resampler
// linear-interpolation sample rate converter for stereo frames
// ----------------------------------------------------------------------------
// usage:
//   s_* stream: one stereo input frame per transfer, signed fractions.
//   m_* stream: interpolated frames as rounded, saturated int16 pairs;
//     m_tlast marks the final result produced for an input frame.
//   apb port: register 0 at byte address 0 is the Q2.F phase step
//     (input frames per output frame), reset value 1.0.
// input: a frame yielding k results (0 to 8) closes the input until its
//   last result is issued (a frame with none leaves it open), one result
//   per cycle while the output does not stall; the first frame after
//   reset is stored only and yields no result.
// path: a frame's first result is issued, then passes four pipeline stages.
// reset: previous frame, phase and pipeline are cleared, the step goes
//   back to 1.0; the next frame is again treated as the first.
// stall: while m_tvalid is high and m_tready low the whole pipeline holds
//   and no new result is issued; a frame can still be taken while the
//   pipe drains results of the one before.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stereo_linear_resampler_assert.svh"

module stereo_linear_resampler import slr_pkg::*; #(
	parameter int SAMPLE_BITS     = 24,
	parameter int PHASE_FRAC_BITS = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// input stream
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	// [SAMPLE_BITS-1:0] left_sample, [2*SAMPLE_BITS-1:SAMPLE_BITS] right_sample
	input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	// output stream
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	// [15:0] left_out, [31:16] right_out
	output logic [2*OUT_BITS-1:0]        m_tdata,
	// last_of_run
	output logic                         m_tlast,
	// configuration
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [APB_ADDR_W-1:0]   paddr,
	input  wire logic [31:0]             pwdata,
	output logic      [31:0]             prdata,
	output logic                         pready
);

	localparam int S = SAMPLE_BITS;

	slr_cmd_t                      cmd;
	slr_status_t                   status;
	logic [PHASE_FRAC_BITS+1:0]    phase_step;
	logic signed [S-1:0]           left_sample;
	logic signed [S-1:0]           right_sample;
	logic signed [OUT_BITS-1:0]    left_out;
	logic signed [OUT_BITS-1:0]    right_out;

	// unpack the input frame, lowest field first
	assign left_sample  = s_tdata[S-1:0];
	assign right_sample = s_tdata[2*S-1:S];

	// phase step register
	slr_regs #(
		.PHASE_FRAC_BITS (PHASE_FRAC_BITS)
	) u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.phase_step (phase_step)
	);

	// sequencer: frame accept, run of issues, run end
	slr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// storage, phase and interpolation pipe
	slr_datapath #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.PHASE_FRAC_BITS (PHASE_FRAC_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.phase_step   (phase_step),
		.cmd          (cmd),
		.status       (status),
		.m_tready     (m_tready),
		.m_tvalid     (m_tvalid),
		.left_out     (left_out),
		.right_out    (right_out),
		.last_of_run  (m_tlast)
	);

	// pack the result, lowest field first
	assign m_tdata = {right_out, left_out};

	// no issue while the input side is open
	`SLR_ASSERT_SAME(a_no_issue_when_idle, clk, arst_n, s_tready, !cmd.issue)
	// a frame with no result leaves the input open
	`SLR_ASSERT_NEXT(a_skip_stays_idle, clk, arst_n, cmd.skip, s_tready)
	// the final issue of a run reopens the input
	`SLR_ASSERT_NEXT(a_last_ends_run, clk, arst_n, cmd.issue_last, s_tready)
	// the first frame is remembered
	`SLR_ASSERT_NEXT(a_first_sets_prev, clk, arst_n, cmd.load_first, status.have_prev)

endmodule

`default_nettype wire

FILE: design/slr_regs.sv
// ----------------------------------------------------------------------------
// slr_regs
// apb register file holding the phase step
// ----------------------------------------------------------------------------
`default_nettype none

module slr_regs import slr_pkg::*; #(
	parameter int PHASE_FRAC_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [APB_ADDR_W-1:0]       paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	output logic      [PHASE_FRAC_BITS+1:0]  phase_step
);

	localparam int ST_W = PHASE_FRAC_BITS + 2;
	localparam logic [ST_W-1:0] STEP_RESET = ST_W'(1) << PHASE_FRAC_BITS;

	logic [ST_W-1:0] step_q;
	logic            wr_en;
	logic            reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (wr_en && (reg_idx == REG_PHASE_STEP)) begin
			step_q <= pwdata[ST_W-1:0];
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PHASE_STEP: prdata = 32'(step_q);
			default:        prdata = 32'd0;
		endcase
	end

	assign phase_step = step_q;

endmodule

`default_nettype wire

FILE: design/slr_ctrl.sv
// ----------------------------------------------------------------------------
// slr_ctrl
// frame sequencer: accepts frames and, while the output does not stall, issues one interpolation per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module slr_ctrl import slr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire slr_status_t status,
	output slr_cmd_t         cmd
);

	slr_state_t       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd            = '0;
		cmd.load_first = accept && !status.have_prev;
		cmd.load_next  = accept && status.have_prev;
		cmd.skip       = cmd.load_next && !status.phase_lt_one;
		cmd.issue      = (state_q == ST_RUN) && status.adv;
		cmd.issue_last = cmd.issue &&
			(!status.sum_lt_one || (cnt_q == CNT_W'(MAX_RESULTS - 1)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load_next && status.phase_lt_one) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					if (cmd.issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (cmd.issue_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: design/slr_datapath.sv
// ----------------------------------------------------------------------------
// slr_datapath
// frame storage, phase accumulator and four-stage interpolation pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module slr_datapath import slr_pkg::*; #(
	parameter int SAMPLE_BITS     = 24,
	parameter int PHASE_FRAC_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic signed [SAMPLE_BITS-1:0]     left_sample,
	input  wire logic signed [SAMPLE_BITS-1:0]     right_sample,
	input  wire logic        [PHASE_FRAC_BITS+1:0] phase_step,
	input  wire slr_cmd_t                          cmd,
	output slr_status_t                            status,
	input  wire logic                              m_tready,
	output logic                                   m_tvalid,
	output logic signed      [OUT_BITS-1:0]        left_out,
	output logic signed      [OUT_BITS-1:0]        right_out,
	output logic                                   last_of_run
);

	localparam int S    = SAMPLE_BITS;
	localparam int F    = PHASE_FRAC_BITS;
	localparam int PH_W = F + 3;
	localparam int D_W  = S + 1;
	localparam int P_W  = S + F + 2;
	localparam int M_W  = S + F;
	localparam int SH   = S - 1 + F;
	localparam int X_W  = M_W + SCALE_LOG2;
	localparam logic [PH_W-1:0] PHASE_ONE = PH_W'(1) << F;

	logic signed [S-1:0]   cur     [2];
	logic signed [S-1:0]   prev_q  [2];
	logic signed [S-1:0]   base_q  [2];
	logic signed [D_W-1:0] diff_q  [2];
	logic                  have_prev_q;
	logic [PH_W-1:0]       phase_q;
	logic [PH_W-1:0]       sum;
	logic                  adv;

	logic signed [P_W-1:0] prod     [2];
	logic signed [P_W-1:0] prod_s1  [2];
	logic signed [S-1:0]   base_s1  [2];
	logic signed [P_W-1:0] y        [2];
	logic signed [P_W-1:0] y_s2     [2];
	logic [M_W-1:0]        mag      [2];
	logic [M_W-1:0]        mag_s3   [2];
	logic                  neg_s3   [2];
	logic signed [OUT_BITS-1:0] res [2];
	logic signed [OUT_BITS-1:0] out_s4 [2];
	logic v_s1, v_s2, v_s3, v_s4;
	logic last_s1, last_s2, last_s3, last_s4;

	assign cur[0] = left_sample;
	assign cur[1] = right_sample;

	assign sum = phase_q + PH_W'(phase_step);
	assign adv = !v_s4 || m_tready;

	assign status.have_prev    = have_prev_q;
	assign status.phase_lt_one = (phase_q[PH_W-1:F] == '0);
	assign status.sum_lt_one   = (sum[PH_W-1:F] == '0);
	assign status.adv          = adv;

	// frame storage and phase accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			phase_q     <= '0;
			prev_q[0]   <= '0;
			prev_q[1]   <= '0;
		end else begin
			if (cmd.load_first || cmd.load_next) begin
				prev_q[0] <= cur[0];
				prev_q[1] <= cur[1];
			end
			if (cmd.load_first) begin
				have_prev_q <= 1'b1;
			end
			if (cmd.skip) begin
				phase_q <= phase_q - PHASE_ONE;
			end else if (cmd.issue) begin
				if (!cmd.issue_last) begin
					phase_q <= sum;
				end else if (status.sum_lt_one) begin
					phase_q <= '0;
				end else begin
					phase_q <= sum - PHASE_ONE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_next) begin
			for (int i = 0; i < 2; i++) begin
				base_q[i] <= prev_q[i];
				diff_q[i] <= D_W'(cur[i]) - D_W'(prev_q[i]);
			end
		end
	end

	// per-lane arithmetic
	always_comb begin
		logic [X_W-1:0]      x;
		logic [OUT_BITS-1:0] q;
		logic                up;
		logic [OUT_BITS:0]   qr;
		for (int i = 0; i < 2; i++) begin
			prod[i] = P_W'(diff_q[i]) * P_W'($signed({1'b0, phase_q[F-1:0]}));
			y[i]    = (P_W'(base_s1[i]) <<< F) + prod_s1[i];
			mag[i]  = y_s2[i][P_W-1] ? M_W'(-y_s2[i]) : M_W'(y_s2[i]);

			// mag * 32767, round to nearest with ties to even, saturate
			x  = {mag_s3[i], {SCALE_LOG2{1'b0}}} - X_W'(mag_s3[i]);
			q  = x[X_W-1:SH];
			up = x[SH-1] && ((|x[SH-2:0]) || q[0]);
			qr = {1'b0, q} + (OUT_BITS+1)'(up);
			if (neg_s3[i]) begin
				res[i] = (qr > MAG_LIMIT_NEG) ? OUT_MIN : OUT_BITS'(-qr);
			end else begin
				res[i] = (qr > MAG_LIMIT_POS) ? OUT_MAX : qr[OUT_BITS-1:0];
			end
		end
	end

	// pipeline control, whole pipe holds while the output waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= cmd.issue_last;
			last_s2 <= last_s1;
			last_s3 <= last_s2;
			last_s4 <= last_s3;
			for (int i = 0; i < 2; i++) begin
				prod_s1[i] <= prod[i];
				base_s1[i] <= base_q[i];
				y_s2[i]    <= y[i];
				mag_s3[i]  <= mag[i];
				neg_s3[i]  <= y_s2[i][P_W-1];
				out_s4[i]  <= res[i];
			end
		end
	end

	assign m_tvalid    = v_s4;
	assign left_out    = out_s4[0];
	assign right_out   = out_s4[1];
	assign last_of_run = last_s4;

endmodule

`default_nettype wire
